// File: hw/rtl/dzcf_pkg.sv
package dzcf_pkg;

    localparam int COUNT_WIDTH   = 24;
    localparam int FRACTION_BITS = 8;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int THRESH_W = 15;
    localparam int FREQ_W   = 26;

    // dividend is the rate scaled up by the fraction bits
    localparam int NUM_W  = RATE_W + FRACTION_BITS;
    localparam int WIDE_W = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
    localparam int STEP_W = $clog2(NUM_W) + 1;

    localparam logic [FREQ_W-1:0]   FREQ_MAX     = '1;
    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(48000);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(5000);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = RATE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_THRESHOLD = CFG_INDEX_W'(1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                   measure;
        logic [COUNT_WIDTH-1:0] period;
    } cmd_t;

    typedef struct packed {
        logic dividing;
    } back_status_t;

endpackage

// File: hw/rtl/dzcf_if.sv
interface sample_if;
    import dzcf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface result_if;
    import dzcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency_q8;
    logic              new_measurement;

    modport source (output valid, output frequency_q8, output new_measurement, input ready);
    modport sink   (input valid, input frequency_q8, input new_measurement, output ready);
endinterface

interface cfg_if;
    import dzcf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dzcf_front.sv
module dzcf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dzcf_pkg::THRESH_W-1:0]    threshold,
    sample_if.sink                           samples,
    output logic                             push_valid,
    input  logic                             push_ready,
    output dzcf_pkg::cmd_t                   push_cmd
);
    import dzcf_pkg::*;

    logic                   last_neg_reg, last_neg_next;
    logic                   seen_reg, seen_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag;
    logic                in_zone;
    logic                f_neg;
    logic                crossing;
    logic                accept;

    always_comb
    begin
        raw     = samples.sample;
        mag     = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
        // nonzero sample below the threshold is zeroed, so it is never negative
        in_zone = (raw != '0) && (mag < {1'b0, threshold});
        f_neg   = raw[SAMPLE_W-1] && !in_zone;
        crossing = last_neg_reg && !f_neg;
    end

    assign accept          = samples.valid && push_ready;
    assign samples.ready   = push_ready;
    assign push_valid      = samples.valid;
    assign push_cmd.measure = crossing && seen_reg && (count_reg != '0);
    assign push_cmd.period  = count_reg;

    always_comb
    begin
        last_neg_next = last_neg_reg;
        seen_next     = seen_reg;
        count_next    = count_reg;
        if (accept)
        begin
            last_neg_next = f_neg;
            if (crossing)
            begin
                seen_next  = 1'b1;
                count_next = COUNT_WIDTH'(1);
            end
            else if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_neg_reg <= 1'b0;
            seen_reg     <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            last_neg_reg <= last_neg_next;
            seen_reg     <= seen_next;
            count_reg    <= count_next;
        end
    end

endmodule

// File: hw/rtl/dzcf_queue.sv
module dzcf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dzcf_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dzcf_pkg::cmd_t pop_cmd
);
    import dzcf_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (fill_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/dzcf_back.sv
module dzcf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dzcf_pkg::RATE_W-1:0]  rate,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  dzcf_pkg::cmd_t               cmd,
    result_if.source                     results,
    output dzcf_pkg::back_status_t       status
);
    import dzcf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FINISH} state_t;

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]      out_freq_reg, out_freq_next;
    logic                   out_new_reg, out_new_next;
    logic [FREQ_W-1:0]      held_reg, held_next;

    logic [NUM_W-1:0]       num_reg, num_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] divisor_reg, divisor_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic [COUNT_WIDTH:0]   trial;
    logic                   fits;
    logic [WIDE_W-1:0]      q_wide;
    logic [FREQ_W-1:0]      q_sat;

    assign cmd_ready               = (state_reg == S_IDLE) && (!out_valid_reg || results.ready);
    assign results.valid           = out_valid_reg;
    assign results.frequency_q8    = out_freq_reg;
    assign results.new_measurement = out_new_reg;
    assign status.dividing         = (state_reg != S_IDLE);

    always_comb
    begin
        // restoring division: one quotient bit per cycle, shifted into num_reg
        trial  = {rem_reg, num_reg[NUM_W-1]};
        fits   = (trial >= {1'b0, divisor_reg});
        q_wide = WIDE_W'(num_reg);
        q_sat  = (q_wide > WIDE_W'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(q_wide);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_freq_next  = out_freq_reg;
        out_new_next   = out_new_reg;
        held_next      = held_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.measure)
                    begin
                        state_next   = S_DIV;
                        num_next     = NUM_W'({rate, {FRACTION_BITS{1'b0}}});
                        rem_next     = '0;
                        divisor_next = cmd.period;
                        step_next    = STEP_W'(NUM_W - 1);
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_freq_next  = held_reg;
                        out_new_next   = 1'b0;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = fits ? COUNT_WIDTH'(trial - {1'b0, divisor_reg})
                                : trial[COUNT_WIDTH-1:0];
                num_next = {num_reg[NUM_W-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                out_valid_next = 1'b1;
                // a zero quotient leaves the held value alone
                if (num_reg != '0)
                begin
                    held_next     = q_sat;
                    out_freq_next = q_sat;
                    out_new_next  = 1'b1;
                end
                else
                begin
                    out_freq_next = held_reg;
                    out_new_next  = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_freq_reg  <= '0;
            out_new_reg   <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_freq_reg  <= out_freq_next;
            out_new_reg   <= out_new_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
    end

endmodule

// File: hw/rtl/deadzone_zero_crossing_frequency.sv
// Path: a sample's command is registered in the queue, then the back end loads the result
//   register; a sample that completes a measurement first passes through S_DIV and S_FINISH.
// Throughput: one sample per cycle between crossings while the queue has room; a measuring
//   crossing holds the divider (one quotient bit per cycle), a 4-entry queue absorbs input.
// Reset: sample_rate 48000, noise_threshold 5000, counters, flags and held frequency cleared.
module deadzone_zero_crossing_frequency (
    input  logic     clk,
    input  logic     rst_n,
    sample_if.sink   samples,
    result_if.source results,
    cfg_if.sink      cfg
);
    import dzcf_pkg::*;

    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [THRESH_W-1:0] thresh_reg, thresh_next;

    logic         push_valid;
    logic         push_ready;
    cmd_t         push_cmd;
    logic         cmd_valid;
    logic         cmd_ready;
    cmd_t         cmd;
    back_status_t back_status;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        rate_next   = rate_reg;
        thresh_next = thresh_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SAMPLE_RATE:     rate_next   = cfg.data[RATE_W-1:0];
                REG_NOISE_THRESHOLD: thresh_next = cfg.data[THRESH_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else
        begin
            rate_reg   <= rate_next;
            thresh_reg <= thresh_next;
        end
    end

    dzcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (thresh_reg),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    dzcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    dzcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rate      (rate_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .results   (results),
        .status    (back_status)
    );

    a_new_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.new_measurement |-> results.frequency_q8 != '0)
        else $error("new measurement with zero frequency");

    a_div_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.dividing |-> !results.valid)
        else $error("result pending while divider busy");

    a_div_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.dividing |-> !(cmd_valid && cmd_ready))
        else $error("command taken while divider busy");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import dzcf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              fresh;
    } reading_t;

    typedef struct packed {
        logic                   is_write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    sample;
        logic                   typed;
        reading_t               want;
    } row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sample_if s_if ();
    result_if r_if ();
    cfg_if    c_if ();

    deadzone_zero_crossing_frequency dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (s_if),
        .results (r_if),
        .cfg     (c_if)
    );

    // meter state as the block should hold it
    logic [RATE_W-1:0]      m_rate   = RATE_RESET;
    logic [THRESH_W-1:0]    m_thresh = THRESH_RESET;
    logic                   m_was_neg = 1'b0;
    logic [COUNT_WIDTH-1:0] m_count  = '0;
    logic                   m_armed  = 1'b0;
    logic [FREQ_W-1:0]      m_held   = '0;

    reading_t meter_readings [$];
    row_t     directed [$];

    int tx_pct        = 0;
    int rx_pct        = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int errors        = 0;
    int n_samples     = 0;
    int n_results     = 0;
    int n_fresh       = 0;
    int n_writes      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic reading_t meter_step(input logic signed [SAMPLE_W-1:0] raw);
        int            s;
        int            f;
        int            t;
        logic [63:0]   quot;
        reading_t      r;
        s = int'(raw);
        t = int'(m_thresh);
        f = s;
        if ((s < 0 && s > -t) || (s > 0 && s < t))
            f = 0;
        r.fresh = 1'b0;
        if (m_was_neg && f >= 0)
        begin
            if (m_armed && m_count != '0)
            begin
                quot = (64'(m_rate) << FRACTION_BITS) / 64'(m_count);
                if (quot > 64'(FREQ_MAX))
                    quot = 64'(FREQ_MAX);
                if (quot != 0)
                begin
                    m_held  = quot[FREQ_W-1:0];
                    r.fresh = 1'b1;
                end
            end
            m_armed = 1'b1;
            m_count = '0;
        end
        if (m_count != '1)
            m_count++;
        m_was_neg = (f < 0);
        r.freq    = m_held;
        return r;
    endfunction

    function automatic row_t smp(input int x);
        row_t r = '0;
        r.sample = SAMPLE_W'(x);
        return r;
    endfunction

    function automatic row_t smp_is(input int x, input int f, input logic n);
        row_t r = smp(x);
        r.typed      = 1'b1;
        r.want.freq  = FREQ_W'(f);
        r.want.fresh = n;
        return r;
    endfunction

    function automatic row_t wr(input logic [CFG_INDEX_W-1:0] i, input int d);
        row_t r = '0;
        r.is_write = 1'b1;
        r.index    = i;
        r.data     = CFG_DATA_W'(d);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] strong_negative();
        int lo;
        lo = (m_thresh == 0) ? 1 : int'(m_thresh);
        return SAMPLE_W'(-int'($urandom_range(32768, lo)));
    endfunction

    function automatic logic [SAMPLE_W-1:0] non_negative();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(3))
            0: v = '0;
            // small negative that the dead zone swallows
            1: v = (m_thresh > 1) ? SAMPLE_W'(-int'($urandom_range(m_thresh - 1, 1))) : '0;
            default: v = SAMPLE_W'($urandom_range(32767));
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] wave_sample(input logic want_neg, input logic noisy);
        logic [SAMPLE_W-1:0] v;
        if (noisy && $urandom_range(7) == 0)
            v = SAMPLE_W'($urandom);
        else
            v = want_neg ? strong_negative() : non_negative();
        return v;
    endfunction

    task automatic put_sample(input logic signed [SAMPLE_W-1:0] x, input logic typed,
                              input reading_t want);
        reading_t got;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            s_if.valid <= 1'b0;
            @(posedge clk);
        end
        s_if.valid  <= 1'b1;
        s_if.sample <= x;
        @(posedge clk);
        while (!s_if.ready)
            @(posedge clk);
        got = meter_step(x);
        meter_readings.push_back(typed ? want : got);
        n_samples++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        c_if.valid <= 1'b1;
        c_if.index <= idx;
        c_if.data  <= d;
        @(posedge clk);
        while (!c_if.ready)
            @(posedge clk);
        if (idx == REG_SAMPLE_RATE)
            m_rate = d[RATE_W-1:0];
        else if (idx == REG_NOISE_THRESHOLD)
            m_thresh = d[THRESH_W-1:0];
        n_writes++;
    endtask

    // hold the sender until every reading is back and the block has gone quiet
    task automatic settle();
        s_if.valid <= 1'b0;
        while (meter_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic drive_wave(input int count, input int neg_max, input int pos_min,
                              input int pos_max, input logic noisy);
        int sent;
        int neg_len;
        int pos_len;
        sent = 0;
        while (sent < count)
        begin
            // now and then drop the negative half so no crossing forms
            neg_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(neg_max, 1);
            pos_len = $urandom_range(pos_max, pos_min);
            repeat (neg_len) put_sample(wave_sample(1'b1, noisy), 1'b0, '0);
            repeat (pos_len) put_sample(wave_sample(1'b0, noisy), 1'b0, '0);
            sent += neg_len + pos_len;
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [FREQ_W-1:0] want,
                                 input logic [FREQ_W-1:0] got);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    task automatic take_reading(input logic [FREQ_W-1:0] freq, input logic fresh);
        reading_t want;
        n_results++;
        if (meter_readings.size() == 0)
        begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("%0t: result beat with no sample outstanding", $time);
        end
        else
        begin
            want = meter_readings.pop_front();
            if (want.fresh)
                n_fresh++;
            if (freq !== want.freq)
                flag_mismatch("frequency_q8", want.freq, freq);
            if (fresh !== want.fresh)
                flag_mismatch("new_measurement", FREQ_W'(want.fresh), FREQ_W'(fresh));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            r_if.ready <= 1'b0;
        else
        begin
            if (r_if.valid && r_if.ready)
                take_reading(r_if.frequency_q8, r_if.new_measurement);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                r_if.ready <= 1'b0;
            end
            else
                r_if.ready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_if.valid && s_if.ready) || (r_if.valid && r_if.ready) ||
                (c_if.valid && c_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] rate;
        logic [CFG_DATA_W-1:0] thr;

        s_if.valid  = 1'b0;
        s_if.sample = '0;
        c_if.valid  = 1'b0;
        c_if.index  = '0;
        c_if.data   = '0;
        r_if.ready  = 1'b0;

        directed.push_back(smp_is(32767, 0, 1'b0));   // first sample cannot cross
        directed.push_back(smp_is(-32768, 0, 1'b0));  // most negative passes the dead zone
        directed.push_back(smp_is(0, 0, 1'b0));       // first crossing only arms
        directed.push_back(smp_is(-4999, 0, 1'b0));
        directed.push_back(smp_is(4999, 0, 1'b0));
        directed.push_back(smp(-5000));
        directed.push_back(smp(5000));
        directed.push_back(smp(-32768));
        directed.push_back(smp(1));
        directed.push_back(wr(REG_NOISE_THRESHOLD, 0));
        directed.push_back(smp(-1));
        directed.push_back(smp(1));
        directed.push_back(wr(REG_SAMPLE_RATE, 0));   // zero quotient keeps the held value
        directed.push_back(smp(-1));
        directed.push_back(smp(0));
        directed.push_back(wr(REG_SAMPLE_RATE, 'h3FFFF));
        directed.push_back(wr(REG_NOISE_THRESHOLD, 'h3FFFF));
        directed.push_back(wr(REG_SPARE_2, 'h3FFFF));
        directed.push_back(wr(REG_SPARE_3, 0));
        directed.push_back(smp(-32767));
        directed.push_back(smp(-32766));
        directed.push_back(smp(-32768));
        directed.push_back(smp(32766));
        directed.push_back(smp(-32768));
        directed.push_back(smp(32767));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < directed.size(); k++)
        begin
            if (directed[k].is_write)
            begin
                if (k == 0 || !directed[k-1].is_write)
                    settle();
                write_reg(directed[k].index, directed[k].data);
                if (k + 1 == directed.size() || !directed[k+1].is_write)
                    c_if.valid <= 1'b0;
            end
            else
                put_sample(directed[k].sample, directed[k].typed, directed[k].want);
        end

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin rate = RATE_RESET; thr = CFG_DATA_W'(THRESH_RESET); end
                1: begin rate = CFG_DATA_W'($urandom); thr = CFG_DATA_W'($urandom); end
                2: begin rate = CFG_DATA_W'(192000); thr = '0; end
                3: begin rate = CFG_DATA_W'('h3FFFF); thr = CFG_DATA_W'(32767); end
                4: begin rate = CFG_DATA_W'(1); thr = CFG_DATA_W'($urandom_range(2000)); end
                5:
                begin
                    rate = CFG_DATA_W'($urandom_range('h3FFFF, 1));
                    thr  = CFG_DATA_W'($urandom_range(32767));
                end
                6: begin rate = CFG_DATA_W'($urandom_range(1000, 1)); thr = CFG_DATA_W'($urandom); end
                default: begin rate = CFG_DATA_W'($urandom); thr = CFG_DATA_W'($urandom); end
            endcase
            settle();
            write_reg(REG_SAMPLE_RATE, rate);
            write_reg(REG_NOISE_THRESHOLD, thr);
            if (p % 2 == 1)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
            c_if.valid <= 1'b0;
            tx_pct = (p % 4 == 1) ? 55 : (p % 4 == 3) ? 6 : 0;
            rx_pct = (p % 4 == 2) ? 55 : (p % 4 == 3) ? 6 : 0;
            // stall the result side long enough to back up the input
            if (p == 0)
                hold_requests++;
            if (p == 4)
            begin
                drive_wave(1, 3, 30, 50, 1'b1);
                drive_wave(1, 2, 258, 262, 1'b0);
                drive_wave(12, 3, 2, 6, 1'b1);
            end
            else
                drive_wave(12, 6, 1, 6, 1'b1);
        end

        settle();
        repeat (NUM_W + 8) @(posedge clk);

        $display("covered %0d samples, %0d results, %0d new measurements, %0d register writes",
                 n_samples, n_results, n_fresh, n_writes);
        $display("dead zone 0 to full scale, rates 0 to max, long periods, stalls and idle mixes");
        if (errors == 0 && meter_readings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
